// File: hdl/sha256_pkg.sv
// Shared constants and functions for the SHA-256 digest engine.
// Depends on nothing; used by every module in this folder.
`default_nettype none
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;
  localparam int unsigned DigestWords = 8;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    begin
      case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    begin
      case (t)
        6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
        6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
        6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
        6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
        6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
        6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
        6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
        6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
        6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
        6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
        6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
        6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
        6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
        6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
        6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
        6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
        6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
        6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
        6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
        6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
        6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
        default: r = 32'hc67178f2;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic load;  // copy hash into working variables, block into window
    logic step;  // run one round
    logic fold;  // add working variables into hash
    logic init;  // reload initial hash values
  } rnd_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/sha256_round.sv
// One SHA-256 round unit, reused for all 64 rounds, with the hash words,
// working variables and schedule window. Depends on sha256_pkg.
`default_nettype none
module sha256_round (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sha256_pkg::rnd_ctrl_t  ctrl,
  input  wire logic [5:0]             round,
  input  wire logic [511:0]           block,
  input  wire logic [2:0]             rd_index,
  output logic [31:0]                 rd_word
);

  logic [31:0] hash [8];
  logic [31:0] v [8];
  logic [31:0] win [16];

  logic [31:0] w, s0, s1, t1, t2, w2, w7, w15, w16;

  // Schedule word: direct for the first 16 rounds, else expanded.
  always_comb begin
    w2 = win[14];
    w7 = win[9];
    w15 = win[1];
    w16 = win[0];
    s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    w = (round < 6'd16) ? w16 : (s1 + w7 + s0 + w16);
    t1 = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11)
         ^ sha256_pkg::rotr(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha256_pkg::round_k(round) + w;
    t2 = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13)
         ^ sha256_pkg::rotr(v[0], 22)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign rd_word = hash[rd_index];

  // Hash words carry reset values; the rest is payload.
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::init_hash(3'(i));
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
    end
  end

  // Working variables and a shifting 16-word window (oldest word at 0).
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
      for (int i = 0; i < 16; i++) win[i] <= block[511 - 32*i -: 32];
    end else if (ctrl.step) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sha256_digest_engine.sv
// Top level of the SHA-256 digest engine: byte gathering, padding sequencer
// and digest output. Depends on sha256_pkg and sha256_round.
//
// Channel | Dir | tdata                               | tuser / tlast
// s_axis  | in  | [7:0] data_byte                     | tuser[0] byte_valid, tlast end_of_message
// m_axis  | out | [31:0] digest_word                  | tuser[2:0] word_index, tlast last_word
//
// A byte that does not complete a block is only accepted. A byte that fills a
// block is accepted, then come one load, 64 rounds of the shared round unit and
// one fold. End of message shifts padding in one byte per cycle up to the end
// of the block, then compresses it; with fewer than nine free bytes a second
// block is padded and compressed in the same way. Then come eight output
// transactions. Reset is synchronous; the input is not ready while a block
// pads or compresses or the digest drains, and the output holds under stall.
`default_nettype none
module sha256_digest_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] byte_valid
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
  } state_t;

  state_t state;
  logic [63:0] count;
  logic [511:0] block;  // byte shift register, first byte of the block on top
  logic [5:0] round;
  logic [2:0] oidx;
  logic [5:0] fill;     // byte position within the current block
  logic finishing;      // end of message pending
  logic marked;         // the 0x80 pad byte is already in place
  logic last_blk;       // block being built or compressed carries the length
  logic [63:0] bit_len;
  logic [7:0] pad_byte;
  sha256_pkg::rnd_ctrl_t ctrl;
  logic [31:0] rd_word;
  logic acc;

  assign s_axis_tready = (state == ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign bit_len = {count[60:0], 3'b000};

  // Padding byte for the current fill position.
  always_comb begin
    if (!marked) begin
      pad_byte = sha256_pkg::PadByte;
    end else if (last_blk && fill >= sha256_pkg::LenPos) begin
      pad_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    ctrl.load = (state == ST_LOAD);
    ctrl.step = (state == ST_ROUND);
    ctrl.fold = (state == ST_FOLD);
    ctrl.init = (state == ST_OUT) && m_axis_tready && (oidx == 3'd7);
  end

  sha256_round u_round (
    .clk(clk), .rst(rst), .ctrl(ctrl), .round(round),
    .block(block), .rd_index(oidx), .rd_word(rd_word)
  );

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = rd_word;
  assign m_axis_tuser = oidx;
  assign m_axis_tlast = (oidx == 3'd7);

  // Block shift register: message bytes, then padding one byte per cycle.
  always_ff @(posedge clk) begin
    if (acc && s_axis_tuser) begin
      block <= {block[503:0], s_axis_tdata};
    end else if (state == ST_PAD) begin
      block <= {block[503:0], pad_byte};
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      round <= '0;
      oidx <= '0;
      fill <= '0;
      finishing <= 1'b0;
      marked <= 1'b0;
      last_blk <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (s_axis_tuser) begin
              count <= count + 64'd1;
              fill <= fill + 6'd1;
            end
            finishing <= s_axis_tlast;
            if (s_axis_tuser && fill == 6'd63) state <= ST_LOAD;
            else if (s_axis_tlast) state <= ST_PAD;
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          marked <= 1'b1;
          // The length fits behind the pad byte only below position 56.
          if (!marked) last_blk <= (fill < sha256_pkg::LenPos);
          if (fill == 6'd63) state <= ST_LOAD;
        end
        ST_LOAD: begin
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (last_blk) begin
            last_blk <= 1'b0;
            oidx <= '0;
            state <= ST_OUT;
          end else if (finishing) begin
            // A second pad block after the pad byte holds only zeros and the length.
            last_blk <= marked;
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              count <= '0;
              finishing <= 1'b0;
              marked <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/sha256_digest_checker.sv
// Checker for the SHA-256 digest engine: watches both stream channels, keeps
// its own SHA-256 state and compares every digest word. Depends on nothing.
`default_nettype none
module sha256_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               fail_count,
  output int               words_pending,
  output int               digests_done
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  logic [63:0]  byte_count;
  digest_word_t expected_words [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the current block into the chaining value.
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  // Absorb one input transaction; on end of message pad and queue the digest.
  task automatic absorb(input logic [7:0] data, input logic has_byte, input logic eom);
    int          pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    if (has_byte) begin
      pos = int'(byte_count[5:0]);
      blk[pos] = data;
      byte_count = byte_count + 1;
      if (pos == 63) compress();
    end
    if (eom) begin
      bit_len = byte_count << 3;
      pos = int'(byte_count[5:0]);
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin blk[pos] = 8'h00; pos++; end
        compress();
        pos = 0;
      end
      while (pos < 56) begin blk[pos] = 8'h00; pos++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.index = 3'(i);
        dw.last = (i == 7);
        expected_words.push_back(dw);
        chain[i] = H_INIT[i];
      end
      byte_count = '0;
    end
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
      byte_count = '0;
      expected_words.delete();
      fail_count = 0;
      digests_done = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest transaction: word=%h index=%0d last=%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.word !== m_axis_tdata || exp_w.index !== m_axis_tuser ||
              exp_w.last !== m_axis_tlast) begin
            fail_count++;
            $display("%0t: digest mismatch: expected word=%h index=%0d last=%b, got word=%h index=%0d last=%b",
                     $time, exp_w.word, exp_w.index, exp_w.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
          if (m_axis_tlast) digests_done++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    words_pending = expected_words.size();
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench top for the SHA-256 digest engine: clock, reset, byte stimulus,
// output back-pressure and verdict. Depends on sha256_digest_engine and the checker.
`default_nettype none
module tb_top;

  localparam int WatchdogLimit = 20000;
  localparam int DirectedItems = 120;
  localparam int RandomItems = 50;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          words_pending;
  int          digests_done;
  int          items_sent;
  int          idle_cycles;
  bit          calm_phase;
  bit          hold_req;

  sha256_digest_engine dut (.*);

  sha256_digest_checker checker_i (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Send one transaction, holding it until accepted; random gaps before it.
  task automatic send(input logic [7:0] data, input logic has_byte, input logic eom);
    int gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // A message of len random bytes, with optional idle items mixed in.
  task automatic send_message(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        send(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(0, 1))
        send(8'($urandom), 1'b1, 1'b1);
      else
        send(8'($urandom), 1'b1, 1'b0);
    end
    if (len == 0 || !s_axis_tlast) send(8'($urandom), 1'b0, 1'b1);
  endtask

  // Output back-pressure: random short stalls, one long hold on request.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("sha256_digest_engine verification failed");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    int drain;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    calm_phase = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, idle item, byte extremes, single-byte messages.
    send(8'hff, 1'b0, 1'b1);
    send(8'h5a, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b1);
    send(8'h80, 1'b1, 1'b0);
    send(8'h7f, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);

    // Padding boundaries: 55 and 56 bytes, then a long hold on the output
    // while the digest of the second one is still in the works.
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    hold_req = 1'b1;

    // Random messages: mostly short, some across block boundaries.
    while (items_sent < DirectedItems + RandomItems) begin
      case ($urandom_range(0, 5))
        0: send_message($urandom_range(0, 70), 1'b1);
        1: send(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: send_message($urandom_range(0, 12), 1'b1);
      endcase
      if (items_sent > DirectedItems + RandomItems - 25) calm_phase = 1'b1;
    end
    send(8'h00, 1'b0, 1'b1);
    s_axis_tvalid <= 1'b0;

    // Drain remaining digest words, then allow a quiet tail.
    drain = 0;
    while (words_pending != 0 && drain < WatchdogLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);

    $display("Sent %0d input transactions, covering %0d digests including empty,", items_sent,
             digests_done);
    $display("padding boundary and multi-block messages under output back-pressure.");
    if (fail_count == 0 && words_pending == 0)
      $display("sha256_digest_engine verification clean");
    else
      $display("sha256_digest_engine verification failed");
    $finish;
  end

endmodule
`default_nettype wire
